[rtl/psd_pkg.sv]
// psd_pkg: shared types, widths and constants of the pulse shape discriminator
// no dependencies; imported by the channel interfaces and the top level module

package psd_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int VERDICT_W    = 3;
  localparam int TRIG_IDX_W   = 13;
  localparam int AREA_OUT_W   = 28;
  localparam int BASE_W       = 20;
  localparam int NOISE_W      = 38;

  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 24;

  localparam int THR_W        = 16;
  localparam int NOISE_LIM_W  = 20;
  localparam int PCT_W        = 7;
  localparam int AREA_LIM_W   = 24;
  localparam int OFF_W        = 12;
  localparam int MIN_TRIG_W   = 12;

  localparam logic [THR_W-1:0]       THR_RST       = 16'd60;
  localparam logic [NOISE_LIM_W-1:0] NOISE_LIM_RST = 20'd900;
  localparam logic [PCT_W-1:0]       TAIL_LOW_RST  = 7'd30;
  localparam logic [PCT_W-1:0]       TAIL_HIGH_RST = 7'd60;
  localparam logic [AREA_LIM_W-1:0]  AREA_LIM_RST  = 24'd50000;
  localparam logic [OFF_W-1:0]       OFF_RST       = 12'd0;
  localparam logic [MIN_TRIG_W-1:0]  MIN_TRIG_RST  = 12'd73;

  localparam int TAIL_SCALE   = 100;

  localparam int DEF_BASELINE_SAMPLES = 60;
  localparam int DEF_PRE_TRIGGER      = 5;
  localparam int DEF_HEAD_SAMPLES     = 10;
  localparam int DEF_POST_TRIGGER     = 112;
  localparam int DEF_MAX_SAMPLES      = 4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRIG_THR,
    REG_NOISE_LIM,
    REG_TAIL_LOW,
    REG_TAIL_HIGH,
    REG_AREA_LIM,
    REG_TRIG_OFF,
    REG_MIN_TRIG
  } cfg_reg_t;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_PASS,
    VERDICT_NOISY,
    VERDICT_EARLY,
    VERDICT_TAIL,
    VERDICT_AREA
  } verdict_t;

  typedef enum logic [3:0] {
    ST_COLLECT,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_SCAN,
    ST_WIN_SETUP,
    ST_WIN,
    ST_TAIL,
    ST_MUL_TAIL,
    ST_MUL_HIGH,
    ST_MUL_LOW,
    ST_CUT
  } psd_state_t;

endpackage

[rtl/psd_in_if.sv]
// psd_in_if: sample channel, valid/ready handshake with one adc sample per transfer
// depends on psd_pkg

interface psd_in_if import psd_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);

endinterface

[rtl/psd_out_if.sv]
// psd_out_if: result channel, valid/ready handshake with one verdict per transfer
// depends on psd_pkg

interface psd_out_if import psd_pkg::*; ();

  logic                         valid;
  logic                         ready;
  logic [VERDICT_W-1:0]         verdict;
  logic signed [TRIG_IDX_W-1:0] trigger_index;
  logic signed [AREA_OUT_W-1:0] head_area;
  logic signed [AREA_OUT_W-1:0] total_area;
  logic [BASE_W-1:0]            baseline_level;
  logic [NOISE_W-1:0]           noise_sum;

  modport source (output valid, output verdict, output trigger_index, output head_area,
                  output total_area, output baseline_level, output noise_sum, input ready);
  modport sink   (input valid, input verdict, input trigger_index, input head_area,
                  input total_area, input baseline_level, input noise_sum, output ready);

endinterface

[rtl/psd_wave_ram.sv]
// psd_wave_ram: waveform store, one write port and one registered read port
// no dependencies

module psd_wave_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/psd_div.sv]
// psd_div: restoring divider, one quotient bit per cycle
// no dependencies; used for the baseline mean

module psd_div #(
  parameter int NUM_W = 26,
  parameter int DEN_W = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [NUM_W-1:0] q_r;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign trial = {rem_r, q_r[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
      q_r   <= {q_r[NUM_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

[rtl/pulse_shape_discriminator.sv]
// pulse_shape_discriminator: charge comparison pulse shape discrimination, top level
// depends on psd_pkg, psd_in_if, psd_out_if, psd_wave_ram, psd_div

// Samples are taken one per clock into the waveform store while in_ch.ready is high.
// After the sample marked last, in_ch.ready drops and the block works through the
// stored waveform: the bit-serial baseline divider, one store read per cycle for the
// noise and trigger scan (ending once the baseline samples are summed and a trigger
// is found, or at the end of the waveform), one store read per cycle over the
// integration window, and the cuts on the shared multiplier.
// The result then sits in the output register and collection of the next waveform
// starts at once; a result not yet taken holds back only the next waveform's cuts.

module pulse_shape_discriminator
  import psd_pkg::*;
#(
  parameter int BASELINE_SAMPLES = DEF_BASELINE_SAMPLES,
  parameter int PRE_TRIGGER      = DEF_PRE_TRIGGER,
  parameter int HEAD_SAMPLES     = DEF_HEAD_SAMPLES,
  parameter int POST_TRIGGER     = DEF_POST_TRIGGER,
  parameter int MAX_SAMPLES      = DEF_MAX_SAMPLES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  psd_in_if.sink                in_ch,
  psd_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W  = $clog2(MAX_SAMPLES);
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int NB_W   = $clog2(BASELINE_SAMPLES + 1);
  localparam int ACC_W  = SAMPLE_W + NB_W;
  localparam int NUM_W  = ACC_W + 4;
  localparam int D_W    = BASE_W + 1;
  localparam int AW     = D_W + $clog2(PRE_TRIGGER + POST_TRIGGER + 1);
  localparam int OP_W   = AW + 1;
  localparam int P_W    = 2 * OP_W;
  localparam int SQ_W   = 2 * BASE_W + NB_W;
  localparam int SUM_W  = CNT_W + $clog2(POST_TRIGGER + HEAD_SAMPLES + 1) + 1;
  localparam int TOFF_W = (IDX_W > OFF_W ? IDX_W : OFF_W) + 1;
  localparam int CMPQ_W = SQ_W > NOISE_LIM_W + 8 ? SQ_W : NOISE_LIM_W + 8;
  localparam int CA_W   = (AW > AREA_LIM_W + 4 ? AW : AREA_LIM_W + 4) + 1;
  localparam int HX_W   = AW > AREA_OUT_W ? AW : AREA_OUT_W;
  localparam int NS_W   = SQ_W - 8;
  localparam int NSX_W  = NS_W > NOISE_W ? NS_W : NOISE_W;

  localparam logic signed [TOFF_W-1:0] TI_MAX = TOFF_W'(2 ** (TRIG_IDX_W - 1) - 1);
  localparam logic signed [TOFF_W-1:0] TI_MIN = ~TI_MAX;
  localparam logic signed [HX_W-1:0]   A_MAX  = HX_W'(2 ** (AREA_OUT_W - 1) - 1);
  localparam logic signed [HX_W-1:0]   A_MIN  = ~A_MAX;
  localparam logic [NSX_W-1:0]         NS_MAX = NSX_W'({NOISE_W{1'b1}});

  // configuration registers
  logic [THR_W-1:0]       thr_r;
  logic [NOISE_LIM_W-1:0] noise_lim_r;
  logic [PCT_W-1:0]       tail_low_r;
  logic [PCT_W-1:0]       tail_high_r;
  logic [AREA_LIM_W-1:0]  area_lim_r;
  logic [OFF_W-1:0]       off_r;
  logic [MIN_TRIG_W-1:0]  min_trig_r;

  psd_state_t state_r, state_nxt;

  // collection
  logic [CNT_W-1:0] count_r;
  logic [ACC_W-1:0] acc_r;
  logic             in_xfer;
  logic             store_we;

  // divider
  logic [NB_W-1:0]  nb_c;
  logic [NUM_W-1:0] div_num;
  logic             div_start;
  logic             div_done;
  logic [NUM_W-1:0] div_quo;

  // store passes
  logic [CNT_W-1:0]        n_r;
  logic [NB_W-1:0]         nb_r;
  logic [BASE_W-1:0]       base_r;
  logic [CNT_W-1:0]        k_r;
  logic                    p1_v_r;
  logic [CNT_W-1:0]        p1_k_r;
  logic [SAMPLE_W-1:0]     mem_q;
  logic signed [D_W-1:0]   d_c;
  logic signed [D_W-1:0]   thr16;
  logic signed [D_W-1:0]   d_r;
  logic                    sqv_r;
  logic                    mulv_r;
  logic [SQ_W-1:0]         sq_r;
  logic                    found_r;
  logic [IDX_W-1:0]        trig_r;
  logic                    scan_issue;
  logic                    win_issue;
  logic                    issue;

  // window
  logic [CNT_W-1:0]        start_c;
  logic [SUM_W-1:0]        tpost_c;
  logic [CNT_W-1:0]        end_c;
  logic [CNT_W-1:0]        end_r;
  logic [SUM_W-1:0]        hend_r;
  logic signed [AW-1:0]    head_r;
  logic signed [AW-1:0]    total_r;

  // shared multiplier and cuts
  logic signed [OP_W-1:0]  tail_r;
  logic signed [OP_W-1:0]  mul_a;
  logic signed [OP_W-1:0]  mul_b;
  logic signed [P_W-1:0]   mul_p_r;
  logic signed [P_W-1:0]   t100_r;
  logic signed [P_W-1:0]   hi_r;
  logic signed [TOFF_W-1:0] toff_c;
  logic                    noisy_c;
  logic                    early_c;
  logic                    tail_bad_c;
  logic                    area_bad_c;
  verdict_t                verdict_c;
  logic signed [HX_W-1:0]  head_x;
  logic signed [HX_W-1:0]  total_x;
  logic [NSX_W-1:0]        ns_x;
  logic                    out_load;

  // output register
  logic                         out_valid_r;
  logic [VERDICT_W-1:0]         verdict_r;
  logic signed [TRIG_IDX_W-1:0] trig_idx_r;
  logic signed [AREA_OUT_W-1:0] head_out_r;
  logic signed [AREA_OUT_W-1:0] total_out_r;
  logic [BASE_W-1:0]            base_out_r;
  logic [NOISE_W-1:0]           noise_out_r;

  assign in_ch.ready = (state_r == ST_COLLECT);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign store_we    = in_xfer && (32'(count_r) < 32'(MAX_SAMPLES));

  psd_wave_ram #(
    .DEPTH (MAX_SAMPLES),
    .WIDTH (SAMPLE_W)
  ) u_ram (
    .clk   (clk),
    .we    (store_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (in_ch.sample),
    .raddr (k_r[IDX_W-1:0]),
    .rdata (mem_q)
  );

  always_comb begin
    if (32'(count_r) < 32'(BASELINE_SAMPLES)) begin
      nb_c = NB_W'(count_r);
    end else begin
      nb_c = NB_W'(BASELINE_SAMPLES);
    end
    if (nb_c == '0) begin
      nb_c = NB_W'(1);
    end
  end

  assign div_num = {acc_r, 4'h0} + NUM_W'(nb_c >> 1);

  psd_div #(
    .NUM_W (NUM_W),
    .DEN_W (NB_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (nb_c),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign d_c   = $signed({1'b0, mem_q, 4'h0}) - $signed({1'b0, base_r});
  assign thr16 = $signed({1'b0, thr_r, 4'h0});
  assign issue = scan_issue || win_issue;

  // window bounds
  always_comb begin
    if (32'(trig_r) >= 32'(PRE_TRIGGER)) begin
      start_c = CNT_W'(trig_r) - CNT_W'(PRE_TRIGGER);
    end else begin
      start_c = '0;
    end
    tpost_c = SUM_W'(trig_r) + SUM_W'(POST_TRIGGER);
    end_c   = (tpost_c < SUM_W'(n_r)) ? CNT_W'(tpost_c) : n_r;
  end

  // state machine
  always_comb begin
    state_nxt  = state_r;
    div_start  = 1'b0;
    scan_issue = 1'b0;
    win_issue  = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      ST_COLLECT: begin
        if (in_xfer && in_ch.last) begin
          state_nxt = ST_DIV_START;
        end
      end
      ST_DIV_START: begin
        div_start = 1'b1;
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        scan_issue = (k_r < n_r) && !(found_r && (32'(k_r) >= 32'(nb_r)));
        if (!scan_issue && !p1_v_r && !sqv_r && !mulv_r) begin
          state_nxt = ST_WIN_SETUP;
        end
      end
      ST_WIN_SETUP: begin
        state_nxt = ST_WIN;
      end
      ST_WIN: begin
        win_issue = k_r < end_r;
        if (!win_issue && !p1_v_r) begin
          state_nxt = ST_TAIL;
        end
      end
      ST_TAIL:     state_nxt = ST_MUL_TAIL;
      ST_MUL_TAIL: state_nxt = ST_MUL_HIGH;
      ST_MUL_HIGH: state_nxt = ST_MUL_LOW;
      ST_MUL_LOW:  state_nxt = ST_CUT;
      ST_CUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_COLLECT;
        end
      end
      default: state_nxt = ST_COLLECT;
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    case (state_r)
      ST_SCAN: begin
        mul_a = OP_W'(d_r);
        mul_b = OP_W'(d_r);
      end
      ST_MUL_TAIL: begin
        mul_a = tail_r;
        mul_b = OP_W'(TAIL_SCALE);
      end
      ST_MUL_HIGH: begin
        mul_a = OP_W'(total_r);
        mul_b = $signed(OP_W'(tail_high_r));
      end
      default: begin
        mul_a = OP_W'(total_r);
        mul_b = $signed(OP_W'(tail_low_r));
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COLLECT;
      count_r     <= '0;
      acc_r       <= '0;
      p1_v_r      <= 1'b0;
      sqv_r       <= 1'b0;
      mulv_r      <= 1'b0;
      out_valid_r <= 1'b0;
      thr_r       <= THR_RST;
      noise_lim_r <= NOISE_LIM_RST;
      tail_low_r  <= TAIL_LOW_RST;
      tail_high_r <= TAIL_HIGH_RST;
      area_lim_r  <= AREA_LIM_RST;
      off_r       <= OFF_RST;
      min_trig_r  <= MIN_TRIG_RST;
    end else begin
      state_r <= state_nxt;
      p1_v_r  <= issue;
      sqv_r   <= p1_v_r && (state_r == ST_SCAN) && (32'(p1_k_r) < 32'(nb_r));
      mulv_r  <= sqv_r;
      if (store_we) begin
        count_r <= count_r + CNT_W'(1);
        if (32'(count_r) < 32'(BASELINE_SAMPLES)) begin
          acc_r <= acc_r + ACC_W'(in_ch.sample);
        end
      end else if (state_r == ST_DIV_START) begin
        count_r <= '0;
        acc_r   <= '0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_TRIG_THR:  thr_r       <= cfg_data[THR_W-1:0];
          REG_NOISE_LIM: noise_lim_r <= cfg_data[NOISE_LIM_W-1:0];
          REG_TAIL_LOW:  tail_low_r  <= cfg_data[PCT_W-1:0];
          REG_TAIL_HIGH: tail_high_r <= cfg_data[PCT_W-1:0];
          REG_AREA_LIM:  area_lim_r  <= cfg_data[AREA_LIM_W-1:0];
          REG_TRIG_OFF:  off_r       <= cfg_data[OFF_W-1:0];
          REG_MIN_TRIG:  min_trig_r  <= cfg_data[MIN_TRIG_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    mul_p_r <= mul_a * mul_b;
    p1_k_r  <= k_r;
    d_r     <= d_c;
    if (issue) begin
      k_r <= k_r + CNT_W'(1);
    end
    if (mulv_r) begin
      sq_r <= sq_r + SQ_W'(mul_p_r);
    end
    if (p1_v_r && state_r == ST_SCAN && !found_r && d_c > thr16) begin
      found_r <= 1'b1;
      trig_r  <= p1_k_r[IDX_W-1:0];
    end
    if (p1_v_r && state_r == ST_WIN) begin
      total_r <= total_r + AW'(d_c);
      if (SUM_W'(p1_k_r) < hend_r) begin
        head_r <= head_r + AW'(d_c);
      end
    end
    case (state_r)
      ST_DIV_START: begin
        n_r     <= count_r;
        nb_r    <= nb_c;
        k_r     <= '0;
        found_r <= 1'b0;
        trig_r  <= IDX_W'(PRE_TRIGGER);
        sq_r    <= '0;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          base_r <= div_quo[BASE_W-1:0];
        end
      end
      ST_WIN_SETUP: begin
        k_r     <= start_c;
        end_r   <= end_c;
        hend_r  <= SUM_W'(start_c) + SUM_W'(HEAD_SAMPLES);
        head_r  <= '0;
        total_r <= '0;
      end
      ST_TAIL:     tail_r <= OP_W'(total_r) - OP_W'(head_r);
      ST_MUL_HIGH: t100_r <= mul_p_r;
      ST_MUL_LOW:  hi_r   <= mul_p_r;
      default: ;
    endcase
  end

  // cuts, low tail product is still in the multiplier register
  assign toff_c     = $signed(TOFF_W'(trig_r)) - $signed(TOFF_W'(off_r));
  assign noisy_c    = CMPQ_W'(sq_r) > CMPQ_W'({noise_lim_r, 8'h00});
  assign early_c    = toff_c < $signed(TOFF_W'(min_trig_r));
  assign tail_bad_c = total_r[AW-1] || (total_r == '0) || (t100_r > hi_r) ||
                      (t100_r < mul_p_r);
  assign area_bad_c = CA_W'(total_r) > $signed(CA_W'({area_lim_r, 4'h0}));

  always_comb begin
    if (noisy_c) begin
      verdict_c = VERDICT_NOISY;
    end else if (early_c) begin
      verdict_c = VERDICT_EARLY;
    end else if (tail_bad_c) begin
      verdict_c = VERDICT_TAIL;
    end else if (area_bad_c) begin
      verdict_c = VERDICT_AREA;
    end else begin
      verdict_c = VERDICT_PASS;
    end
  end

  assign head_x  = HX_W'(head_r);
  assign total_x = HX_W'(total_r);
  assign ns_x    = NSX_W'(sq_r >> 8);

  always_ff @(posedge clk) begin
    if (out_load) begin
      verdict_r <= verdict_c;
      if (toff_c > TI_MAX) begin
        trig_idx_r <= TRIG_IDX_W'(TI_MAX);
      end else if (toff_c < TI_MIN) begin
        trig_idx_r <= TRIG_IDX_W'(TI_MIN);
      end else begin
        trig_idx_r <= TRIG_IDX_W'(toff_c);
      end
      if (head_x > A_MAX) begin
        head_out_r <= AREA_OUT_W'(A_MAX);
      end else if (head_x < A_MIN) begin
        head_out_r <= AREA_OUT_W'(A_MIN);
      end else begin
        head_out_r <= AREA_OUT_W'(head_x);
      end
      if (total_x > A_MAX) begin
        total_out_r <= AREA_OUT_W'(A_MAX);
      end else if (total_x < A_MIN) begin
        total_out_r <= AREA_OUT_W'(A_MIN);
      end else begin
        total_out_r <= AREA_OUT_W'(total_x);
      end
      base_out_r  <= base_r;
      noise_out_r <= (ns_x > NS_MAX) ? {NOISE_W{1'b1}} : NOISE_W'(ns_x);
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.verdict        = verdict_r;
  assign out_ch.trigger_index  = trig_idx_r;
  assign out_ch.head_area      = head_out_r;
  assign out_ch.total_area     = total_out_r;
  assign out_ch.baseline_level = base_out_r;
  assign out_ch.noise_sum      = noise_out_r;

endmodule
